[design/snde_pkg.sv]
// Shared types and constants for the sensor normalize / difference-over-sum block.
// No dependencies; used by sensor_normalize_diff_ratio_error and snde_chk.
`timescale 1ns / 1ps

package snde_pkg;

   // Channel order of one sample beat.
   localparam int CHANNELS = 6;
   localparam int CH_LH    = 0;
   localparam int CH_LV    = 1;
   localparam int CH_MH    = 2;
   localparam int CH_MV    = 3;
   localparam int CH_RH    = 4;
   localparam int CH_RV    = 5;

   // Field widths.
   localparam int NORM_W = 7;
   localparam int ERR_W  = 14;
   localparam int GAIN_W = 12;

   // Arithmetic constants.
   localparam int NORM_SPAN = 99;
   localparam int MID_FLOOR = 25;
   localparam int ERR_SCALE = 4800;
   localparam int ONE_Q8    = 256;

   // Register indexes of the configuration port.
   typedef enum logic [1:0] {
      CSR_MIN_LEVEL  = 2'd0,
      CSR_MAX_LEVEL  = 2'd1,
      CSR_HORIZ_GAIN = 2'd2,
      CSR_VERT_GAIN  = 2'd3
   } csr_index_type;

   typedef logic [NORM_W-1:0] norm_type;

endpackage

[design/sensor_normalize_diff_ratio_error.sv]
// Throughput: one beat per cycle; each stage holds only while the stage after it is
// full and stalled, so bubbles close up and a stall loses nothing.
// Depth is set by the two pipelined dividers (4 and 7 stages, two quotient bits each).
// Reset (synchronous) empties the pipeline and loads the register defaults.
// Depends on snde_pkg and snde_div.
`timescale 1ns / 1ps

module sensor_normalize_diff_ratio_error #(
   parameter int SAMPLE_BITS = 12
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              req_valid,
   output logic                                              req_stall,
   input  logic [SAMPLE_BITS-1:0]                            req_left_horiz,
   input  logic [SAMPLE_BITS-1:0]                            req_left_vert,
   input  logic [SAMPLE_BITS-1:0]                            req_mid_horiz,
   input  logic [SAMPLE_BITS-1:0]                            req_mid_vert,
   input  logic [SAMPLE_BITS-1:0]                            req_right_horiz,
   input  logic [SAMPLE_BITS-1:0]                            req_right_vert,
   output logic                                              rsp_valid,
   input  logic                                              rsp_stall,
   output logic [snde_pkg::NORM_W-1:0]                       rsp_norm_left_horiz,
   output logic [snde_pkg::NORM_W-1:0]                       rsp_norm_left_vert,
   output logic [snde_pkg::NORM_W-1:0]                       rsp_norm_mid_horiz,
   output logic [snde_pkg::NORM_W-1:0]                       rsp_norm_mid_vert,
   output logic [snde_pkg::NORM_W-1:0]                       rsp_norm_right_horiz,
   output logic [snde_pkg::NORM_W-1:0]                       rsp_norm_right_vert,
   output logic signed [snde_pkg::ERR_W-1:0]                 rsp_track_error,
   input  logic                                              csr_valid,
   output logic                                              csr_ready,
   input  logic [1:0]                                        csr_index,
   input  logic [((SAMPLE_BITS > snde_pkg::GAIN_W) ?
                  SAMPLE_BITS : snde_pkg::GAIN_W)-1:0]       csr_wdata
);

   localparam int SB    = SAMPLE_BITS;
   localparam int PRW   = SB + 7;       // offset times 99
   localparam int NSTG  = 18;
   localparam int D1    = 4;            // normalize divider stages
   localparam int D2    = 7;            // error divider stages
   localparam int GW    = snde_pkg::GAIN_W;
   localparam int NW7   = snde_pkg::NORM_W;
   localparam int MAGW  = 20;           // |numerator|
   localparam int DENW  = 21;           // denominator
   localparam int DVDW  = 33;           // |numerator| * 4800
   localparam int QW    = 13;           // error quotient

   // Configuration registers.
   logic [SB-1:0] min_ff, max_ff;
   logic [GW-1:0] hg_ff, vg_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= '0;
         max_ff <= SB'(2000);
         hg_ff  <= GW'(snde_pkg::ONE_Q8);
         vg_ff  <= GW'(snde_pkg::ONE_Q8);
      end else if (csr_valid && csr_ready) begin
         unique case (snde_pkg::csr_index_type'(csr_index))
            snde_pkg::CSR_MIN_LEVEL:  min_ff <= csr_wdata[SB-1:0];
            snde_pkg::CSR_MAX_LEVEL:  max_ff <= csr_wdata[SB-1:0];
            snde_pkg::CSR_HORIZ_GAIN: hg_ff  <= csr_wdata[GW-1:0];
            snde_pkg::CSR_VERT_GAIN:  vg_ff  <= csr_wdata[GW-1:0];
            default: ;
         endcase
      end
   end

   // Stage valid bits and the load-enable chain; a stage loads when it is empty
   // or when the stage after it loads.
   logic [NSTG-1:0] v_ff;
   logic [NSTG-1:0] en;

   always_comb begin
      en[NSTG-1] = !v_ff[NSTG-1] || !rsp_stall;
      for (int k = NSTG - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < NSTG; k++) begin
            if (en[k]) begin
               v_ff[k] <= (k == 0) ? req_valid : v_ff[(k == 0) ? 0 : k - 1];
            end
         end
      end
   end

   assign req_stall = !en[0];
   assign rsp_valid = v_ff[NSTG-1];

   // Stage 0: clamp each sample and take its offset from the low level.
   logic [SB-1:0] raw [snde_pkg::CHANNELS];
   logic [SB-1:0] off_ff [snde_pkg::CHANNELS];
   logic [SB-1:0] span0_ff;
   logic          emp_ff [6];

   assign raw[snde_pkg::CH_LH] = req_left_horiz;
   assign raw[snde_pkg::CH_LV] = req_left_vert;
   assign raw[snde_pkg::CH_MH] = req_mid_horiz;
   assign raw[snde_pkg::CH_MV] = req_mid_vert;
   assign raw[snde_pkg::CH_RH] = req_right_horiz;
   assign raw[snde_pkg::CH_RV] = req_right_vert;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         for (int c = 0; c < snde_pkg::CHANNELS; c++) begin
            if (raw[c] > max_ff) begin
               off_ff[c] <= max_ff - min_ff;
            end else if (raw[c] < min_ff) begin
               off_ff[c] <= '0;
            end else begin
               off_ff[c] <= raw[c] - min_ff;
            end
         end
         span0_ff <= max_ff - min_ff;
      end
   end

   // Empty-range flag rides alongside until the divider result is used.
   always_ff @(posedge clock) begin
      for (int k = 0; k < 6; k++) begin
         if (en[k]) begin
            emp_ff[k] <= (k == 0) ? (max_ff <= min_ff) : emp_ff[(k == 0) ? 0 : k - 1];
         end
      end
   end

   // Stage 1: scale the offset by the normalized span.
   logic [PRW-1:0] prod_ff [snde_pkg::CHANNELS];
   logic [SB-1:0]  span1_ff;

   always_ff @(posedge clock) begin
      if (en[1]) begin
         for (int c = 0; c < snde_pkg::CHANNELS; c++) begin
            prod_ff[c] <= PRW'(off_ff[c]) * PRW'(snde_pkg::NORM_SPAN);
         end
         span1_ff <= span0_ff;
      end
   end

   // Stages 2 to 5: one divider lane per channel.
   logic [NW7-1:0] q1 [snde_pkg::CHANNELS];

   for (genvar c = 0; c < snde_pkg::CHANNELS; c++) begin : g_norm_div
      snde_div #(
         .NW   (PRW),
         .DW   (SB),
         .QB   (NW7),
         .NSTG (D1)
      ) u_div (
         .clock (clock),
         .en    (en[2 +: D1]),
         .dvd   (prod_ff[c]),
         .dvs   (span1_ff),
         .quo   (q1[c])
      );
   end

   // Stage 6: normalized values, middle horizontal raised to its floor.
   // Normalized values then travel alongside the error arithmetic.
   snde_pkg::norm_type nrm_ff [6:16][snde_pkg::CHANNELS];
   snde_pkg::norm_type nrm_in [snde_pkg::CHANNELS];

   always_comb begin
      for (int c = 0; c < snde_pkg::CHANNELS; c++) begin
         nrm_in[c] = emp_ff[5] ? NW7'(1) : q1[c] + NW7'(1);
      end
      if (nrm_in[snde_pkg::CH_MH] < NW7'(snde_pkg::MID_FLOOR)) begin
         nrm_in[snde_pkg::CH_MH] = NW7'(snde_pkg::MID_FLOOR);
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 6; k <= 16; k++) begin
         if (en[k]) begin
            for (int c = 0; c < snde_pkg::CHANNELS; c++) begin
               nrm_ff[k][c] <= (k == 6) ? nrm_in[c] : nrm_ff[(k == 6) ? 6 : k - 1][c];
            end
         end
      end
   end

   // Stage 7: gain products of the pair differences and sums.
   logic signed [7:0]  dh, dv;
   logic        [7:0]  sh, sv;
   logic signed [20:0] pmh_ff, pmv_ff;
   logic        [19:0] psh_ff, psv_ff;

   assign dh = $signed({1'b0, nrm_ff[6][snde_pkg::CH_LH]})
             - $signed({1'b0, nrm_ff[6][snde_pkg::CH_RH]});
   assign dv = $signed({1'b0, nrm_ff[6][snde_pkg::CH_LV]})
             - $signed({1'b0, nrm_ff[6][snde_pkg::CH_RV]});
   assign sh = 8'(nrm_ff[6][snde_pkg::CH_LH]) + 8'(nrm_ff[6][snde_pkg::CH_RH]);
   assign sv = 8'(nrm_ff[6][snde_pkg::CH_LV]) + 8'(nrm_ff[6][snde_pkg::CH_RV]);

   always_ff @(posedge clock) begin
      if (en[7]) begin
         pmh_ff <= $signed({1'b0, hg_ff}) * dh;
         pmv_ff <= $signed({1'b0, vg_ff}) * dv;
         psh_ff <= 20'(hg_ff) * 20'(sh);
         psv_ff <= 20'(vg_ff) * 20'(sv);
      end
   end

   // Stage 8: numerator magnitude and sign, floored denominator.
   logic signed [21:0] num;
   logic [DENW-1:0]    den;
   logic [MAGW-1:0]    mag_ff;
   logic [DENW-1:0]    den_ff;
   logic               neg_ff [8:16];

   assign num = 22'(pmh_ff) + 22'(pmv_ff);
   assign den = DENW'(psh_ff) + DENW'(psv_ff)
              + DENW'({nrm_ff[7][snde_pkg::CH_MH], 8'b0});

   always_ff @(posedge clock) begin
      if (en[8]) begin
         mag_ff <= num[21] ? MAGW'(-num) : MAGW'(num);
         den_ff <= (den < DENW'(snde_pkg::ONE_Q8)) ? DENW'(snde_pkg::ONE_Q8) : den;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 8; k <= 16; k++) begin
         if (en[k]) begin
            neg_ff[k] <= (k == 8) ? num[21] : neg_ff[(k == 8) ? 8 : k - 1];
         end
      end
   end

   // Stage 9: scale the numerator magnitude to Q.4 times 300.
   logic [DVDW-1:0] dvd_ff;
   logic [DENW-1:0] den9_ff;

   always_ff @(posedge clock) begin
      if (en[9]) begin
         dvd_ff  <= DVDW'(mag_ff) * DVDW'(snde_pkg::ERR_SCALE);
         den9_ff <= den_ff;
      end
   end

   // Stages 10 to 16: error divider.
   logic [QW-1:0] q2;

   snde_div #(
      .NW   (DVDW),
      .DW   (DENW),
      .QB   (QW),
      .NSTG (D2)
   ) u_err_div (
      .clock (clock),
      .en    (en[10 +: D2]),
      .dvd   (dvd_ff),
      .dvs   (den9_ff),
      .quo   (q2)
   );

   // Stage 17: response register.
   always_ff @(posedge clock) begin
      if (en[17]) begin
         rsp_norm_left_horiz  <= nrm_ff[16][snde_pkg::CH_LH];
         rsp_norm_left_vert   <= nrm_ff[16][snde_pkg::CH_LV];
         rsp_norm_mid_horiz   <= nrm_ff[16][snde_pkg::CH_MH];
         rsp_norm_mid_vert    <= nrm_ff[16][snde_pkg::CH_MV];
         rsp_norm_right_horiz <= nrm_ff[16][snde_pkg::CH_RH];
         rsp_norm_right_vert  <= nrm_ff[16][snde_pkg::CH_RV];
         rsp_track_error      <= neg_ff[16] ? -$signed({1'b0, q2}) : $signed({1'b0, q2});
      end
   end

endmodule

[design/snde_div.sv]
// Pipelined restoring divider, two quotient bits per register stage.
// Depends on nothing; the caller supplies one load enable per stage.
`timescale 1ns / 1ps

module snde_div #(
   parameter int NW   = 19,
   parameter int DW   = 12,
   parameter int QB   = 7,
   parameter int NSTG = (QB + 1) / 2
) (
   input  logic            clock,
   input  logic [NSTG-1:0] en,
   input  logic [NW-1:0]   dvd,
   input  logic [DW-1:0]   dvs,
   output logic [QB-1:0]   quo
);

   localparam int WW = (NW > DW + QB) ? NW : DW + QB;

   logic [NW-1:0] rem_ff [NSTG];
   logic [DW-1:0] dvs_ff [NSTG];
   logic [QB-1:0] quo_ff [NSTG];
   logic [NW-1:0] rem_in [NSTG];
   logic [DW-1:0] dvs_in [NSTG];
   logic [QB-1:0] quo_in [NSTG];

   // Each stage tries the shifted divisor against the partial remainder twice.
   always_comb begin
      logic [WW-1:0] r;
      logic [WW-1:0] t;
      logic [DW-1:0] d;
      logic [QB-1:0] q;
      int            b;
      for (int s = 0; s < NSTG; s++) begin
         r = (s == 0) ? WW'(dvd) : WW'(rem_ff[(s == 0) ? 0 : s - 1]);
         d = (s == 0) ? dvs : dvs_ff[(s == 0) ? 0 : s - 1];
         q = (s == 0) ? '0 : quo_ff[(s == 0) ? 0 : s - 1];
         for (int j = 0; j < 2; j++) begin
            b = QB - 1 - 2 * s - j;
            if (b >= 0) begin
               t = WW'(d) << b;
               if (r >= t) begin
                  r    = r - t;
                  q[b] = 1'b1;
               end
            end
         end
         rem_in[s] = NW'(r);
         dvs_in[s] = d;
         quo_in[s] = q;
      end
   end

   // Stage registers move only when their enable is high.
   always_ff @(posedge clock) begin
      for (int s = 0; s < NSTG; s++) begin
         if (en[s]) begin
            rem_ff[s] <= rem_in[s];
            dvs_ff[s] <= dvs_in[s];
            quo_ff[s] <= quo_in[s];
         end
      end
   end

   assign quo = quo_ff[NSTG-1];

endmodule

[design/snde_chk.sv]
// Port-level assertions for the sensor normalize block and their bind.
// Depends on snde_pkg; attaches to sensor_normalize_diff_ratio_error.
`timescale 1ns / 1ps

module snde_chk (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_stall,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic [snde_pkg::NORM_W-1:0]        rsp_norm_mid_horiz,
   input logic signed [snde_pkg::ERR_W-1:0]  rsp_track_error
);

   // Nothing comes out in the first cycle after reset is released.
   a_reset_empty: assert property (@(posedge clock) (!reset && $past(reset)) |-> !rsp_valid)
      else $error("response valid right after reset");

   // The input side only backs up when the output side is full and stalled.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without a stalled response");

   // A stalled response beat keeps its error value.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_track_error))
      else $error("stalled response changed");

   // Middle value floor and error range.
   a_mid_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_norm_mid_horiz >= snde_pkg::NORM_W'(snde_pkg::MID_FLOOR))
      else $error("middle value below floor");

   a_err_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_track_error <= 14'sd4800 && rsp_track_error >= -14'sd4800))
      else $error("track error out of range");

endmodule

bind sensor_normalize_diff_ratio_error snde_chk u_snde_chk (.*);
